FILE: sv/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types, constants and helper functions of the separable blur unit.
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int NUM_WEIGHTS = 5;
    localparam int SIZE_W      = 10;
    localparam int COORD_W     = 12;
    localparam int ACC_W       = 28;
    localparam int FRAC_W      = 16;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_RADIUS  = 3'd2;
    localparam logic [2:0] REG_W_CTR   = 3'd3;
    localparam logic [2:0] REG_W_ONE   = 3'd4;
    localparam logic [2:0] REG_W_TWO   = 3'd5;
    localparam logic [2:0] REG_W_THREE = 3'd6;
    localparam logic [2:0] REG_W_FOUR  = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0]                  width_eff;
        logic [SIZE_W-1:0]                  height_eff;
        logic [2:0]                         radius;
        logic [NUM_WEIGHTS-1:0][15:0]       weight;
    } cfg_t;

    // Mirror an index into 0..n-1, clamping when the kernel is wider than the image.
    function automatic logic [SIZE_W-1:0] reflect_index(
        input logic signed [COORD_W-1:0] p,
        input logic [SIZE_W-1:0]         n
    );
        logic signed [COORD_W-1:0] q;
        logic signed [COORD_W-1:0] ns;
        ns = signed'(COORD_W'(n));
        q  = p;
        if (q < 0)
            q = -q - 1;
        if (q >= ns)
            q = ns + ns - q - 1;
        if (q < 0)
            q = '0;
        if (q >= ns)
            q = ns - 1;
        return q[SIZE_W-1:0];
    endfunction

    function automatic logic [7:0] sat_byte(input logic [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W-1:0] v;
        v = acc[ACC_W-1:FRAC_W];
        if (v > (ACC_W-FRAC_W)'(255))
            return 8'hFF;
        return v[7:0];
    endfunction

endpackage

FILE: sv/sgb_regs.sv
// ----------------------------------------------------------------------------
// sgb_regs
// Configuration registers behind the APB port, with effective-size decode.
// ----------------------------------------------------------------------------
module sgb_regs #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output sgb_pkg::cfg_t cfg
);
    import sgb_pkg::*;

    logic [8:0]  width_reg,  width_next;
    logic [8:0]  height_reg, height_next;
    logic [2:0]  radius_reg, radius_next;
    logic [NUM_WEIGHTS-1:0][15:0] weight_reg, weight_next;
    logic [2:0]  idx;
    logic        wr;

    assign idx = paddr[4:2];
    assign wr  = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        radius_next = radius_reg;
        weight_next = weight_reg;
        if (wr)
        begin
            case (idx)
                REG_WIDTH:   width_next     = pwdata[8:0];
                REG_HEIGHT:  height_next    = pwdata[8:0];
                REG_RADIUS:  radius_next    = pwdata[2:0];
                REG_W_CTR:   weight_next[0] = pwdata[15:0];
                REG_W_ONE:   weight_next[1] = pwdata[15:0];
                REG_W_TWO:   weight_next[2] = pwdata[15:0];
                REG_W_THREE: weight_next[3] = pwdata[15:0];
                REG_W_FOUR:  weight_next[4] = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            radius_reg <= 3'd0;
            weight_reg <= {16'd0, 16'd0, 16'd0, 16'd0, 16'd65535};
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            radius_reg <= radius_next;
            weight_reg <= weight_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_WIDTH:   prdata = 32'(width_reg);
            REG_HEIGHT:  prdata = 32'(height_reg);
            REG_RADIUS:  prdata = 32'(radius_reg);
            REG_W_CTR:   prdata = 32'(weight_reg[0]);
            REG_W_ONE:   prdata = 32'(weight_reg[1]);
            REG_W_TWO:   prdata = 32'(weight_reg[2]);
            REG_W_THREE: prdata = 32'(weight_reg[3]);
            REG_W_FOUR:  prdata = 32'(weight_reg[4]);
            default:     prdata = '0;
        endcase
    end

    // Zero acts as one, anything past the frame limit acts as the limit.
    always_comb
    begin
        if (width_reg == 9'd0)
            cfg.width_eff = SIZE_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            cfg.width_eff = SIZE_W'(MAX_WIDTH);
        else
            cfg.width_eff = SIZE_W'(width_reg);

        if (height_reg == 9'd0)
            cfg.height_eff = SIZE_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            cfg.height_eff = SIZE_W'(MAX_HEIGHT);
        else
            cfg.height_eff = SIZE_W'(height_reg);

        if (int'(radius_reg) > MAX_RADIUS)
            cfg.radius = 3'(MAX_RADIUS);
        else
            cfg.radius = radius_reg;

        cfg.weight = weight_reg;
    end

endmodule

FILE: sv/sgb_frame_mem.sv
// ----------------------------------------------------------------------------
// sgb_frame_mem
// Frame store: one write port, one registered read port, 24-bit RGB entries.
// ----------------------------------------------------------------------------
module sgb_frame_mem #(
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [23:0]              wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [23:0]              rd_data
);
    logic [23:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/sgb_core.sv
// ----------------------------------------------------------------------------
// sgb_core
// Read sequencer and multiply-accumulate pipeline for one blurred pixel.
// ----------------------------------------------------------------------------
module sgb_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  sgb_pkg::cfg_t                              cfg,
    input  logic                                       go,
    input  logic [7:0]                                 col_in,
    input  logic [7:0]                                 row_in,
    output logic                                       busy,
    output logic                                       rd_en,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    rd_addr,
    input  logic [23:0]                                rd_data,
    output logic                                       done,
    output logic [7:0]                                 red,
    output logic [7:0]                                 green,
    output logic [7:0]                                 blue
);
    import sgb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);

    state_t state_reg, state_next;
    logic signed [3:0] ki_reg, ki_next, kj_reg, kj_next;
    logic [7:0] colc_reg, rowc_reg;
    logic signed [3:0] rad_s;
    logic [SIZE_W-1:0] cref, rref;
    logic [2:0] dh, dv;

    logic       s1_valid_reg, s1_first_reg, s1_last_reg, s1_rfirst_reg, s1_final_reg;
    logic [2:0] s1_dh_reg, s1_dv_reg;
    logic       s2_valid_reg, s2_rfirst_reg, s2_final_reg;
    logic [2:0] s2_dv_reg;
    logic       s3_valid_reg, s3_rfirst_reg, s3_final_reg;
    logic [2:0] s3_dv_reg;
    logic       s4_valid_reg;
    logic [2:0][ACC_W-1:0] hacc_reg, vacc_reg;
    logic [2:0][7:0]       h_reg;
    logic       done_reg;
    logic [7:0] red_reg, green_reg, blue_reg;

    assign rad_s = signed'({1'b0, cfg.radius});
    assign dh    = ki_reg < 0 ? 3'(-ki_reg) : 3'(ki_reg);
    assign dv    = kj_reg < 0 ? 3'(-kj_reg) : 3'(kj_reg);
    assign cref  = reflect_index(COORD_W'(colc_reg) + COORD_W'(ki_reg), cfg.width_eff);
    assign rref  = reflect_index(COORD_W'(rowc_reg) + COORD_W'(kj_reg), cfg.height_eff);

    assign rd_en   = (state_reg == ST_ISSUE);
    assign rd_addr = AW'(32'(rref) * MAX_WIDTH + 32'(cref));
    assign busy    = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ki_next    = ki_reg;
        kj_next    = kj_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_ISSUE;
                    ki_next    = -rad_s;
                    kj_next    = -rad_s;
                end
            end
            ST_ISSUE:
            begin
                if (ki_reg == rad_s)
                begin
                    ki_next = -rad_s;
                    if (kj_reg == rad_s)
                        state_next = ST_DRAIN;
                    else
                        kj_next = kj_reg + 4'sd1;
                end
                else
                    ki_next = ki_reg + 4'sd1;
            end
            ST_DRAIN:
            begin
                if (s4_valid_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg && s1_last_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && s3_final_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ki_reg <= ki_next;
        kj_reg <= kj_next;
        // Latch the clamped target pixel at acceptance.
        if (go && state_reg == ST_IDLE)
        begin
            colc_reg <= (SIZE_W'(col_in) >= cfg.width_eff)
                        ? 8'(cfg.width_eff - 1'b1) : col_in;
            rowc_reg <= (SIZE_W'(row_in) >= cfg.height_eff)
                        ? 8'(cfg.height_eff - 1'b1) : row_in;
        end

        s1_dh_reg     <= dh;
        s1_dv_reg     <= dv;
        s1_first_reg  <= (ki_reg == -rad_s);
        s1_last_reg   <= (ki_reg == rad_s);
        s1_rfirst_reg <= (kj_reg == -rad_s);
        s1_final_reg  <= (kj_reg == rad_s);

        // Horizontal pass: one stored pixel per cycle.
        if (s1_valid_reg)
        begin
            for (int c = 0; c < 3; c++)
                hacc_reg[c] <= (s1_first_reg ? '0 : hacc_reg[c])
                    + ACC_W'(cfg.weight[s1_dh_reg] * rd_data[8*(2-c) +: 8]);
        end
        s2_dv_reg     <= s1_dv_reg;
        s2_rfirst_reg <= s1_rfirst_reg;
        s2_final_reg  <= s1_final_reg;

        if (s2_valid_reg)
        begin
            for (int c = 0; c < 3; c++)
                h_reg[c] <= sat_byte(hacc_reg[c]);
        end
        s3_dv_reg     <= s2_dv_reg;
        s3_rfirst_reg <= s2_rfirst_reg;
        s3_final_reg  <= s2_final_reg;

        // Vertical pass: one finished row sum per step.
        if (s3_valid_reg)
        begin
            for (int c = 0; c < 3; c++)
                vacc_reg[c] <= (s3_rfirst_reg ? '0 : vacc_reg[c])
                    + ACC_W'(cfg.weight[s3_dv_reg] * h_reg[c]);
        end

        if (s4_valid_reg)
        begin
            red_reg   <= sat_byte(vacc_reg[0]);
            green_reg <= sat_byte(vacc_reg[1]);
            blue_reg  <= sat_byte(vacc_reg[2]);
        end
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: sv/separable_gaussian_blur_rgb_unit.sv
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb_unit
// RGB frame store with an on-demand separable blur and mirrored edges.
// ----------------------------------------------------------------------------
// A write item (mode 0) stores one pixel and completes in the cycle it is
// accepted; busy stays low. A read item (mode 1) raises busy and walks the
// (2R+1) x (2R+1) kernel window through the single frame memory read port,
// one stored pixel per cycle, then finishes the row and column sums in the
// multiply-accumulate pipeline. done pulses for one cycle with the blurred
// color; the receiver cannot stall, so capture it then. The frame memory
// has no reset; read only pixels that were written.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_rgb_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  column,
    input  logic [7:0]  row,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sgb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    cfg_t          cfg;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [23:0]   rd_data;

    assign pready  = 1'b1;
    assign accept  = start && !busy;
    // Drop writes that fall outside the frame.
    assign wr_en   = accept && (mode == MODE_WRITE)
                     && (int'(column) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
    assign wr_addr = AW'(32'(row) * MAX_WIDTH + 32'(column));

    sgb_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sgb_frame_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({red_in, green_in, blue_in}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sgb_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .go      (accept && (mode == MODE_READ)),
        .col_in  (column),
        .row_in  (row),
        .busy    (busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (done),
        .red     (red_out),
        .green   (green_out),
        .blue    (blue_out)
    );

endmodule

FILE: sv/sgb_checker.sv
// ----------------------------------------------------------------------------
// sgb_checker
// Port-level checks of the blur unit, bound to the top level.
// ----------------------------------------------------------------------------
module sgb_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic mode,
    input logic done,
    input logic pready
);
    import sgb_pkg::*;

    // A write item finishes at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode == MODE_WRITE |=> !busy)
        else $error("busy after write item");

    // A read item occupies the unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode == MODE_READ |=> busy)
        else $error("read item not started");

    // A result only follows a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without read item");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind separable_gaussian_blur_rgb_unit sgb_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .mode   (mode),
    .done   (done),
    .pready (pready)
);
